// ----- hw/rtl/led_strip_spark_mover_assert.svh -----
// assertion macros used by the spark mover checker
// depends on nothing, taken in by include
`ifndef LED_STRIP_SPARK_MOVER_ASSERT_SVH
`define LED_STRIP_SPARK_MOVER_ASSERT_SVH

// condition implies consequence in the same cycle
`define LSSM_ASSERT_NOW(label, clk, rst_n, cond, conseq, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (conseq)) \
        else $error(msg);

// condition implies consequence in the next cycle
`define LSSM_ASSERT_NEXT(label, clk, rst_n, cond, conseq, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (conseq)) \
        else $error(msg);

`endif

// ----- hw/rtl/lssm_pkg.sv -----
// types, constants and helpers of the led strip spark mover
// depends on nothing
package lssm_pkg;

    localparam int SPARKS     = 50;
    localparam int MAX_LEDS   = 1024;
    localparam int SLOT_W     = (SPARKS > 1) ? $clog2(SPARKS) : 1;
    localparam int SLOT_OUT_W = 6;
    localparam int POS_W      = 10;
    localparam int LEN_W      = 11;
    localparam int COL_W      = 8;
    localparam int CNT_W      = 2;
    localparam int CFG_ADDR_W = 1;
    localparam int S_DATA_W   = 40;
    localparam int M_DATA_W   = 40;

    localparam logic [CNT_W-1:0] RECOLOUR_BOUNCES    = 2'd3;
    localparam logic [LEN_W-1:0] RESET_STRIP_LENGTH  = 11'd300;

    localparam logic [CFG_ADDR_W-1:0] REG_STRIP_LENGTH = 1'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_BOUNCE_MODE  = 1'd1;

    typedef struct packed {
        logic [COL_W-1:0] red;
        logic [COL_W-1:0] green;
        logic [COL_W-1:0] blue;
    } colour_t;

    // input item, lowest field in the lowest bits
    typedef struct packed {
        logic [4:0]       pad;
        logic [POS_W-1:0] new_position;
        logic             new_direction;
        logic [COL_W-1:0] new_blue;
        logic [COL_W-1:0] new_green;
        logic [COL_W-1:0] new_red;
    } in_item_t;

    typedef struct packed {
        logic [COL_W-1:0]      pixel_blue;
        logic [COL_W-1:0]      pixel_green;
        logic [COL_W-1:0]      pixel_red;
        logic [POS_W-1:0]      pixel_index;
        logic [SLOT_OUT_W-1:0] spark_slot;
    } out_data_t;

    typedef struct packed {
        logic      end_of_frame;
        out_data_t data;
    } result_t;

    typedef struct packed {
        logic [POS_W-1:0] position;
        logic             heading;
        colour_t          colour;
        logic [CNT_W-1:0] bounce_count;
    } spark_state_t;

    localparam int STATE_W = $bits(spark_state_t);

    // highest usable pixel for a strip length register value
    function automatic logic [POS_W-1:0] last_pixel(input logic [LEN_W-1:0] len);
        logic [LEN_W-1:0] dec;
        dec = len - 1'b1;
        if (len == '0) begin
            return '0;
        end else if (int'(len) > MAX_LEDS) begin
            return POS_W'(MAX_LEDS - 1);
        end else begin
            return dec[POS_W-1:0];
        end
    endfunction

endpackage

// ----- hw/rtl/lssm_ram.sv -----
// generic single write port ram with registered read
// depends on nothing
module lssm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                     aclk,
    input  logic                                     wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                         wr_data,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

// ----- hw/rtl/lssm_update.sv -----
// one step of a spark: spawn, draw position and move or respawn or bounce
// depends on lssm_pkg
module lssm_update
    import lssm_pkg::*;
(
    input  in_item_t         in_item,
    input  spark_state_t     cur_state,
    input  logic             spawned,
    input  logic [POS_W-1:0] len_max,
    input  logic             bounce_mode,
    output logic [POS_W-1:0] pixel,
    output colour_t          colour,
    output spark_state_t     new_state
);

    logic [POS_W-1:0] pos_in;
    colour_t          colour_in;
    spark_state_t     st;
    logic             leaving;
    logic [CNT_W-1:0] cnt_inc;

    always_comb begin
        pos_in = (in_item.new_position > len_max) ? len_max : in_item.new_position;
        colour_in.red   = in_item.new_red;
        colour_in.green = in_item.new_green;
        colour_in.blue  = in_item.new_blue;

        if (spawned) begin
            st = cur_state;
        end else begin
            st.position     = pos_in;
            st.heading      = in_item.new_direction;
            st.colour       = colour_in;
            st.bounce_count = '0;
        end

        pixel  = (st.position > len_max) ? len_max : st.position;
        colour = st.colour;

        leaving = st.heading ? (pixel == '0) : (pixel == len_max);
        cnt_inc = st.bounce_count + 1'b1;

        new_state = st;
        if (!leaving) begin
            new_state.position = st.heading ? pixel - 1'b1 : pixel + 1'b1;
        end else if (!bounce_mode) begin
            new_state.position = pos_in;
            new_state.heading  = in_item.new_direction;
            new_state.colour   = colour_in;
        end else begin
            new_state.position = pixel;
            new_state.heading  = ~st.heading;
            if (cnt_inc == RECOLOUR_BOUNCES) begin
                new_state.colour       = colour_in;
                new_state.bounce_count = '0;
            end else begin
                new_state.bounce_count = cnt_inc;
            end
        end
    end

endmodule

// ----- hw/rtl/lssm_skid.sv -----
// output register with skid stage for result items
// depends on lssm_pkg
module lssm_skid
    import lssm_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    in_valid,
    output logic    in_ready,
    input  result_t in_item,
    output logic    out_valid,
    input  logic    out_ready,
    output result_t out_item
);

    logic    out_valid_reg;
    logic    skid_valid_reg;
    result_t out_item_reg;
    result_t skid_item_reg;
    logic    in_fire;

    assign in_ready  = ~skid_valid_reg;
    assign in_fire   = in_valid & in_ready;
    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (!out_valid_reg || out_ready) begin
            out_valid_reg  <= skid_valid_reg | in_fire;
            skid_valid_reg <= 1'b0;
        end else if (in_fire) begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!out_valid_reg || out_ready) begin
            out_item_reg <= skid_valid_reg ? skid_item_reg : in_item;
        end else if (in_fire) begin
            skid_item_reg <= in_item;
        end
    end

endmodule

// ----- hw/rtl/led_strip_spark_mover.sv -----
// top level of the led strip spark mover
// depends on lssm_pkg, lssm_ram, lssm_update and lssm_skid

// Takes one item per cycle while the output stage has room, giving one result
// per item, registered in the cycle after the item is taken when the output is
// free. Items serve the sparks in round-robin order, slot 0 first after reset.
// The spark state sits in a ram read ahead at the slot of the coming item; a
// spawned flag per spark is cleared by reset. A two-deep output stage keeps the
// input open for one more item while a result waits. Write strip_length and
// bounce_mode only when no result is outstanding.
module led_strip_spark_mover
    import lssm_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    // new_red, new_green, new_blue, new_direction, new_position, zero pad
    input  logic [S_DATA_W-1:0]   s_tdata,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // spark_slot, pixel_index, pixel_red, pixel_green, pixel_blue
    output logic [M_DATA_W-1:0]   m_tdata,
    output logic                  m_tlast,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    input  logic                  cfg_wr_en,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [LEN_W-1:0]      cfg_wr_data
);

    logic [SLOT_W-1:0] slot_reg;
    logic [SLOT_W-1:0] slot_next;
    logic [SPARKS-1:0] spawned_reg;
    logic [POS_W-1:0]  len_max_reg;
    logic              bounce_reg;
    logic              fwd_hit_reg;
    spark_state_t      fwd_data_reg;

    logic              accept;
    logic              skid_ready;
    logic [SLOT_W-1:0] rd_addr;
    logic [STATE_W-1:0] ram_rd_data;
    spark_state_t      cur_state;
    spark_state_t      new_state;
    in_item_t          in_item;
    logic [POS_W-1:0]  pixel;
    colour_t           colour;
    result_t           result;
    result_t           out_item;
    logic              last_slot;

    assign s_tready  = skid_ready & aresetn;
    assign accept    = s_tvalid & s_tready;
    assign in_item   = in_item_t'(s_tdata);
    assign last_slot = (slot_reg == SLOT_W'(SPARKS - 1));
    assign slot_next = last_slot ? '0 : slot_reg + 1'b1;
    assign rd_addr   = accept ? slot_next : slot_reg;
    assign cur_state = fwd_hit_reg ? fwd_data_reg : spark_state_t'(ram_rd_data);

    lssm_ram #(
        .WIDTH (STATE_W),
        .DEPTH (SPARKS)
    ) u_state_ram (
        .aclk    (aclk),
        .wr_en   (accept),
        .wr_addr (slot_reg),
        .wr_data (new_state),
        .rd_addr (rd_addr),
        .rd_data (ram_rd_data)
    );

    lssm_update u_update (
        .in_item     (in_item),
        .cur_state   (cur_state),
        .spawned     (spawned_reg[slot_reg]),
        .len_max     (len_max_reg),
        .bounce_mode (bounce_reg),
        .pixel       (pixel),
        .colour      (colour),
        .new_state   (new_state)
    );

    always_comb begin
        result.end_of_frame     = last_slot;
        result.data.spark_slot  = SLOT_OUT_W'(slot_reg);
        result.data.pixel_index = pixel;
        result.data.pixel_red   = colour.red;
        result.data.pixel_green = colour.green;
        result.data.pixel_blue  = colour.blue;
    end

    lssm_skid u_skid (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (accept),
        .in_ready  (skid_ready),
        .in_item   (result),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_item  (out_item)
    );

    assign m_tdata = out_item.data;
    assign m_tlast = out_item.end_of_frame;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            slot_reg    <= '0;
            spawned_reg <= '0;
            fwd_hit_reg <= 1'b0;
        end else begin
            fwd_hit_reg <= accept & (rd_addr == slot_reg);
            if (accept) begin
                slot_reg              <= slot_next;
                spawned_reg[slot_reg] <= 1'b1;
            end
        end
    end

    // same-slot read after write when only one spark exists
    always_ff @(posedge aclk) begin
        fwd_data_reg <= new_state;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            len_max_reg <= last_pixel(RESET_STRIP_LENGTH);
            bounce_reg  <= 1'b0;
        end else if (cfg_wr_en) begin
            unique case (cfg_addr)
                REG_STRIP_LENGTH: len_max_reg <= last_pixel(cfg_wr_data);
                REG_BOUNCE_MODE:  bounce_reg  <= cfg_wr_data[0];
                default: ;
            endcase
        end
    end

endmodule

// ----- hw/rtl/lssm_checker.sv -----
// port-level checks of the led strip spark mover, bound to the top level
// depends on lssm_pkg and led_strip_spark_mover_assert.svh
`include "led_strip_spark_mover_assert.svh"

module lssm_checker
    import lssm_pkg::*;
(
    input logic                  aclk,
    input logic                  aresetn,
    input logic [S_DATA_W-1:0]   s_tdata,
    input logic                  s_tvalid,
    input logic                  s_tready,
    input logic [M_DATA_W-1:0]   m_tdata,
    input logic                  m_tlast,
    input logic                  m_tvalid,
    input logic                  m_tready,
    input logic                  cfg_wr_en,
    input logic [CFG_ADDR_W-1:0] cfg_addr,
    input logic [LEN_W-1:0]      cfg_wr_data
);

    `LSSM_ASSERT_NEXT(a_stall_hold, aclk, aresetn, m_tvalid && !m_tready,
        m_tvalid && $stable(m_tdata) && $stable(m_tlast), "result changed while stalled")

    `LSSM_ASSERT_NOW(a_last_slot, aclk, aresetn, m_tvalid,
        m_tlast == (m_tdata[SLOT_OUT_W-1:0] == SLOT_OUT_W'(SPARKS - 1)), "tlast off last slot")

    `LSSM_ASSERT_NOW(a_slot_range, aclk, aresetn, m_tvalid,
        m_tdata[SLOT_OUT_W-1:0] < SLOT_OUT_W'(SPARKS), "slot beyond spark count")

    `LSSM_ASSERT_NEXT(a_skid_full, aclk, aresetn, s_tvalid && s_tready && m_tvalid && !m_tready,
        !s_tready, "input open with output stage full")

endmodule

bind led_strip_spark_mover lssm_checker u_lssm_checker (.*);
